// ----- design/sws_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sws_pkg
// Shared constants for the spherical wave stencil step unit: request codes,
// register indexes, register reset values and the fixed-point format.
// ---------------------------------------------------------------------------
package sws_pkg;

  localparam int MaxRowsDef    = 128;
  localparam int MaxColsDef    = 256;
  localparam int ValueWidthDef = 32;
  localparam int FracBits      = 20;

  localparam logic [2:0] REQ_WR_CUR = 3'd0;
  localparam logic [2:0] REQ_WR_PRV = 3'd1;
  localparam logic [2:0] REQ_COEF   = 3'd2;
  localparam logic [2:0] REQ_STEP   = 3'd3;
  localparam logic [2:0] REQ_RD_CUR = 3'd4;

  localparam logic [1:0] CFG_ROWS = 2'd0;
  localparam logic [1:0] CFG_COLS = 2'd1;
  localparam logic [1:0] CFG_DAMP = 2'd2;

  localparam logic [7:0]  RowsReset = 8'd96;
  localparam logic [8:0]  ColsReset = 9'd192;
  localparam logic [20:0] DampReset = 21'd1047527;

endpackage

// ----- design/spherical_wave_stencil_step_unit.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// spherical_wave_stencil_step_unit
// Explicit wave-equation stencil on a theta/phi grid closed over the poles.
// Cell writes, coefficient loads and bad requests answer in the cycle after
// start; a cell read answers through S_RDO from a registered value. A step
// updates every active cell, then damps the first and last rows, paced by
// the single shared multiplier and one read port per bank. One request is in
// work at a time; busy_o is high while a cell read or a step is in work.
// Reset clears the bank select and presets the state and config registers;
// grids and tables are kept. The receiver cannot stall the result strobe.
// ---------------------------------------------------------------------------
module spherical_wave_stencil_step_unit #(
  parameter int MAX_ROWS    = sws_pkg::MaxRowsDef,
  parameter int MAX_COLS    = sws_pkg::MaxColsDef,
  parameter int VALUE_WIDTH = sws_pkg::ValueWidthDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic [2:0]         req_type_i,
  input  logic [6:0]         row_index_i,
  input  logic [7:0]         col_index_i,
  input  logic signed [31:0] cell_value_i,
  input  logic signed [31:0] coef_north_i,
  input  logic signed [31:0] coef_south_i,
  input  logic signed [31:0] coef_phi_i,
  output logic               result_valid_o,
  output logic signed [31:0] read_value_o,
  output logic               status_o,
  output logic               saturated_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [20:0]        cfg_data_i
);

  import sws_pkg::*;

  localparam int VW    = VALUE_WIDTH;
  localparam int DEPTH = MAX_ROWS * MAX_COLS;
  localparam int AW    = $clog2(DEPTH);
  localparam int RW    = $clog2(MAX_ROWS);
  localparam int CW    = $clog2(MAX_COLS);
  localparam int RCW   = $clog2(MAX_ROWS + 1);
  localparam int CCW   = $clog2(MAX_COLS + 1);
  localparam int PW    = VW + 33;
  localparam int RPW   = PW - FracBits;
  localparam int ACW   = VW + 16;
  localparam logic signed [63:0] VMAX = (64'sd1 <<< (VW - 1)) - 64'sd1;
  localparam logic signed [63:0] VMIN = -VMAX - 64'sd1;
  localparam logic signed [PW-1:0] HALF_UP = PW'(64'sd1 <<< (FracBits - 1));
  localparam logic signed [PW-1:0] HALF_DN = PW'((64'sd1 <<< (FracBits - 1)) - 64'sd1);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_RDO  = 4'd1;
  localparam logic [3:0] S_CELL = 4'd2;
  localparam logic [3:0] S_DIFF = 4'd3;
  localparam logic [3:0] S_MUL  = 4'd4;
  localparam logic [3:0] S_CWR  = 4'd5;
  localparam logic [3:0] S_DRD  = 4'd6;
  localparam logic [3:0] S_DMUL = 4'd7;
  localparam logic [3:0] S_DWR  = 4'd8;

  function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] r, input logic [CW-1:0] c);
    return AW'(r) * AW'(MAX_COLS) + AW'(c);
  endfunction

  function automatic logic [VW:0] sat_val(input logic signed [ACW-1:0] x);
    if (x > VMAX) begin
      return {1'b1, VMAX[VW-1:0]};
    end else if (x < VMIN) begin
      return {1'b1, VMIN[VW-1:0]};
    end
    return {1'b0, x[VW-1:0]};
  endfunction

  logic [3:0]  state_q, state_d;
  logic [7:0]  rows_q;
  logic [8:0]  cols_q;
  logic [20:0] damp_q;
  logic        sel_q;
  logic [RW-1:0] i_q;
  logic [CW-1:0] j_q;
  logic [2:0]  ph_q;
  logic        dpass_q;
  logic        satf_q;
  logic signed [VW-1:0] u_q, p_q, n_q, s_q, e_q, w_q;
  logic signed [VW-1:0] dn_q, ds_q, dp_q;
  logic signed [ACW-1:0] acc_q;
  logic signed [PW-1:0] prod_q;
  logic signed [31:0] cn_mem [MAX_ROWS];
  logic signed [31:0] cs_mem [MAX_ROWS];
  logic signed [31:0] cp_mem [MAX_ROWS];
  logic signed [31:0] cn_q, cs_q, cp_q;
  logic        rv_q, st_q, so_q;
  logic signed [31:0] rdv_q;

  logic [RCW-1:0] rows_eff;
  logic [CCW-1:0] cols_eff;
  logic [RW-1:0]  last_row, drow;
  logic [CW-1:0]  last_col, half, jf, je, jw;
  logic [CW:0]    jsum;
  logic           row_ok, cell_ok, accept;
  logic [AW-1:0]  cmd_addr, cur_raddr, nxt_raddr, waddr;
  logic           cur_we, nxt_we;
  logic signed [VW-1:0] wdata, cur_rd, nxt_rd, a_rd, b_rd, cmd_val;
  logic signed [63:0] cv64, rd64;
  logic signed [VW-1:0] mul_a;
  logic signed [32:0]   mul_b;
  logic signed [RPW-1:0] rnd;
  logic [VW:0] sat_dn, sat_ds, sat_dp, sat_acc, sat_rnd;

  always_comb begin
    if (rows_q == 8'd0) begin
      rows_eff = RCW'(1);
    end else if (int'(rows_q) > MAX_ROWS) begin
      rows_eff = RCW'(MAX_ROWS);
    end else begin
      rows_eff = RCW'(rows_q);
    end
    if (cols_q < 9'd2) begin
      cols_eff = CCW'(2);
    end else if (int'(cols_q) > MAX_COLS) begin
      cols_eff = CCW'(MAX_COLS);
    end else begin
      cols_eff = CCW'(cols_q);
    end
  end

  assign last_row = RW'(rows_eff - RCW'(1));
  assign last_col = CW'(cols_eff - CCW'(1));
  assign half     = CW'(cols_eff >> 1);
  assign jsum     = {1'b0, j_q} + {1'b0, half};
  assign jf       = (int'(jsum) >= int'(cols_eff)) ? CW'(jsum - (CW+1)'(cols_eff)) : jsum[CW-1:0];
  assign je       = (j_q == last_col) ? '0 : j_q + CW'(1);
  assign jw       = (j_q == '0) ? last_col : j_q - CW'(1);
  assign drow     = dpass_q ? last_row : '0;

  assign row_ok   = int'(row_index_i) < int'(rows_eff);
  assign cell_ok  = row_ok && (int'(col_index_i) < int'(cols_eff));
  assign accept   = start_i && (state_q == S_IDLE);
  assign cmd_addr = cell_addr(RW'(row_index_i), CW'(col_index_i));

  assign cv64 = 64'(cell_value_i);
  always_comb begin
    if (cv64 > VMAX) begin
      cmd_val = VMAX[VW-1:0];
    end else if (cv64 < VMIN) begin
      cmd_val = VMIN[VW-1:0];
    end else begin
      cmd_val = cv64[VW-1:0];
    end
  end

  assign sat_dn = sat_val(ACW'(n_q) - ACW'(u_q));
  assign sat_ds = sat_val(ACW'(s_q) - ACW'(u_q));
  assign sat_dp = sat_val(ACW'(e_q) + ACW'(w_q) - (ACW'(u_q) <<< 1));
  assign rnd = prod_q[PW-1] ? RPW'((prod_q + HALF_DN) >>> FracBits)
                            : RPW'((prod_q + HALF_UP) >>> FracBits);
  assign sat_acc = sat_val(acc_q);
  assign sat_rnd = sat_val(ACW'(rnd));

  always_comb begin
    cur_raddr = cmd_addr;
    nxt_raddr = cell_addr(i_q, j_q);
    cur_we    = 1'b0;
    nxt_we    = 1'b0;
    waddr     = cmd_addr;
    wdata     = cmd_val;
    state_d   = state_q;
    mul_a     = dn_q;
    mul_b     = 33'(cn_q);
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (req_type_i)
            REQ_WR_CUR: cur_we = cell_ok;
            REQ_WR_PRV: nxt_we = cell_ok;
            REQ_STEP:   state_d = S_CELL;
            REQ_RD_CUR: state_d = cell_ok ? S_RDO : S_IDLE;
            default: ;
          endcase
        end
      end
      S_RDO: state_d = S_IDLE;
      S_CELL: begin
        case (ph_q)
          3'd0: cur_raddr = cell_addr(i_q, j_q);
          3'd1: cur_raddr = (i_q == '0) ? cell_addr('0, jf) : cell_addr(i_q - RW'(1), j_q);
          3'd2: cur_raddr = (i_q == last_row) ? cell_addr(i_q, jf)
                                              : cell_addr(i_q + RW'(1), j_q);
          3'd3: cur_raddr = cell_addr(i_q, je);
          default: cur_raddr = cell_addr(i_q, jw);
        endcase
        if (ph_q == 3'd5) begin
          state_d = S_DIFF;
        end
      end
      S_DIFF: state_d = S_MUL;
      S_MUL: begin
        case (ph_q[2:1])
          2'd0: begin
            mul_a = dn_q;
            mul_b = 33'(cn_q);
          end
          2'd1: begin
            mul_a = ds_q;
            mul_b = 33'(cs_q);
          end
          default: begin
            mul_a = dp_q;
            mul_b = 33'(cp_q);
          end
        endcase
        if (ph_q == 3'd5) begin
          state_d = S_CWR;
        end
      end
      S_CWR: begin
        nxt_we = 1'b1;
        waddr  = cell_addr(i_q, j_q);
        wdata  = sat_acc[VW-1:0];
        state_d = (j_q == last_col && i_q == last_row) ? S_DRD : S_CELL;
      end
      S_DRD: begin
        nxt_raddr = cell_addr(drow, j_q);
        state_d   = S_DMUL;
      end
      S_DMUL: begin
        mul_a   = nxt_rd;
        mul_b   = {12'd0, damp_q};
        state_d = S_DWR;
      end
      S_DWR: begin
        nxt_we  = 1'b1;
        waddr   = cell_addr(drow, j_q);
        wdata   = sat_rnd[VW-1:0];
        state_d = (j_q == last_col && dpass_q) ? S_IDLE : S_DRD;
      end
      default: state_d = S_IDLE;
    endcase
  end

  sws_bank #(.DEPTH(DEPTH), .AW(AW), .VW(VW)) u_bank_a (
    .clk_i   (clk_i),
    .we_i    (sel_q ? nxt_we : cur_we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (sel_q ? nxt_raddr : cur_raddr),
    .rdata_o (a_rd)
  );

  sws_bank #(.DEPTH(DEPTH), .AW(AW), .VW(VW)) u_bank_b (
    .clk_i   (clk_i),
    .we_i    (sel_q ? cur_we : nxt_we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (sel_q ? cur_raddr : nxt_raddr),
    .rdata_o (b_rd)
  );

  assign cur_rd = sel_q ? b_rd : a_rd;
  assign nxt_rd = sel_q ? a_rd : b_rd;
  assign rd64   = 64'(cur_rd);

  always_ff @(posedge clk_i) begin
    if (accept && req_type_i == REQ_COEF && row_ok) begin
      cn_mem[RW'(row_index_i)] <= coef_north_i;
      cs_mem[RW'(row_index_i)] <= coef_south_i;
      cp_mem[RW'(row_index_i)] <= coef_phi_i;
    end
    cn_q <= cn_mem[i_q];
    cs_q <= cs_mem[i_q];
    cp_q <= cp_mem[i_q];
    prod_q <= PW'(mul_a) * PW'(mul_b);
    case (ph_q)
      3'd1: begin
        u_q <= cur_rd;
        p_q <= nxt_rd;
      end
      3'd2: n_q <= cur_rd;
      3'd3: s_q <= cur_rd;
      3'd4: e_q <= cur_rd;
      default: w_q <= cur_rd;
    endcase
    if (state_q == S_DIFF) begin
      dn_q  <= sat_dn[VW-1:0];
      ds_q  <= sat_ds[VW-1:0];
      dp_q  <= sat_dp[VW-1:0];
      acc_q <= (ACW'(u_q) <<< 1) - ACW'(p_q);
    end else if (state_q == S_MUL && ph_q[0]) begin
      acc_q <= acc_q + ACW'(rnd);
    end
    if (state_q == S_RDO) begin
      rdv_q <= rd64[31:0];
    end else begin
      rdv_q <= '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      rows_q  <= RowsReset;
      cols_q  <= ColsReset;
      damp_q  <= DampReset;
      sel_q   <= 1'b0;
      i_q     <= '0;
      j_q     <= '0;
      ph_q    <= '0;
      dpass_q <= 1'b0;
      satf_q  <= 1'b0;
      rv_q    <= 1'b0;
      st_q    <= 1'b0;
      so_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      rv_q    <= 1'b0;
      st_q    <= 1'b0;
      so_q    <= 1'b0;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CFG_ROWS: rows_q <= cfg_data_i[7:0];
          CFG_COLS: cols_q <= cfg_data_i[8:0];
          CFG_DAMP: damp_q <= cfg_data_i;
          default: ;
        endcase
      end
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            case (req_type_i)
              REQ_WR_CUR, REQ_WR_PRV: begin
                rv_q <= 1'b1;
                st_q <= !cell_ok;
              end
              REQ_COEF: begin
                rv_q <= 1'b1;
                st_q <= !row_ok;
              end
              REQ_STEP: begin
                i_q     <= '0;
                j_q     <= '0;
                ph_q    <= '0;
                dpass_q <= 1'b0;
                satf_q  <= 1'b0;
              end
              REQ_RD_CUR: begin
                rv_q <= !cell_ok;
                st_q <= !cell_ok;
              end
              default: begin
                rv_q <= 1'b1;
                st_q <= 1'b1;
              end
            endcase
          end
        end
        S_RDO: rv_q <= 1'b1;
        S_CELL: ph_q <= (ph_q == 3'd5) ? 3'd0 : ph_q + 3'd1;
        S_DIFF: satf_q <= satf_q | sat_dn[VW] | sat_ds[VW] | sat_dp[VW];
        S_MUL: ph_q <= (ph_q == 3'd5) ? 3'd0 : ph_q + 3'd1;
        S_CWR: begin
          satf_q <= satf_q | sat_acc[VW];
          if (j_q == last_col) begin
            j_q <= '0;
            if (i_q != last_row) begin
              i_q <= i_q + RW'(1);
            end
          end else begin
            j_q <= j_q + CW'(1);
          end
        end
        S_DWR: begin
          satf_q <= satf_q | sat_rnd[VW];
          if (j_q == last_col) begin
            j_q <= '0;
            if (dpass_q) begin
              sel_q <= !sel_q;
              rv_q  <= 1'b1;
              so_q  <= satf_q | sat_rnd[VW];
            end
            dpass_q <= 1'b1;
          end else begin
            j_q <= j_q + CW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  assign busy_o         = state_q != S_IDLE;
  assign cfg_ready_o    = 1'b1;
  assign result_valid_o = rv_q;
  assign read_value_o   = rdv_q;
  assign status_o       = st_q;
  assign saturated_o    = so_q;

  a_sat_only_after_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    saturated_o |-> result_valid_o && $past(state_q) == S_DWR)
    else $error("saturation flag outside a step result");

  a_step_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && req_type_i == REQ_STEP |=> state_q == S_CELL && !result_valid_o)
    else $error("step did not start");

  a_cell_in_grid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_CELL |-> j_q <= last_col && i_q <= last_row)
    else $error("step walked outside the active grid");

  a_read_answer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_RDO |=> result_valid_o && !status_o)
    else $error("cell read gave no result");

endmodule

// ----- design/sws_bank.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sws_bank
// One grid bank: a single-port-write, single-port-read memory with a
// registered read.
// ---------------------------------------------------------------------------
module sws_bank #(
  parameter int DEPTH = 32768,
  parameter int AW    = 15,
  parameter int VW    = 32
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [AW-1:0]        waddr_i,
  input  logic signed [VW-1:0] wdata_i,
  input  logic [AW-1:0]        raddr_i,
  output logic signed [VW-1:0] rdata_o
);

  logic signed [VW-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// ----- verif/sws_checker.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sws_checker
// Watches the request, result and register channels of the stencil step
// unit. It keeps its own copy of both grid banks, the row coefficient tables
// and the registers, predicts the answer of every accepted request and
// compares each result strobe with the oldest prediction.
// ---------------------------------------------------------------------------
module sws_checker
  import sws_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic               busy_o,
  input  logic [2:0]         req_type_i,
  input  logic [6:0]         row_index_i,
  input  logic [7:0]         col_index_i,
  input  logic signed [31:0] cell_value_i,
  input  logic signed [31:0] coef_north_i,
  input  logic signed [31:0] coef_south_i,
  input  logic signed [31:0] coef_phi_i,
  input  logic               result_valid_o,
  input  logic signed [31:0] read_value_o,
  input  logic               status_o,
  input  logic               saturated_o,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [20:0]        cfg_data_i,
  output int                 fail_count_o,
  output int                 pending_o
);

  typedef struct packed {
    logic signed [31:0] value;
    logic               status;
    logic               sat;
  } answer_t;

  localparam longint CellMax = 64'sd2147483647;
  localparam longint CellMin = -64'sd2147483648;

  answer_t     answers_q[$];
  longint      grid[2][MaxRowsDef * MaxColsDef];
  longint      north_c[MaxRowsDef];
  longint      south_c[MaxRowsDef];
  longint      phi_c[MaxRowsDef];
  bit          cur_sel;
  logic [7:0]  rows_r;
  logic [8:0]  cols_r;
  logic [20:0] damp_r;
  bit          sat_seen;

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
  end

  function automatic int active_rows();
    if (rows_r < 1) return 1;
    if (rows_r > MaxRowsDef) return MaxRowsDef;
    return int'(rows_r);
  endfunction

  function automatic int active_cols();
    if (cols_r < 2) return 2;
    if (cols_r > MaxColsDef) return MaxColsDef;
    return int'(cols_r);
  endfunction

  function automatic longint clamp_cell(longint v);
    if (v > CellMax) begin
      sat_seen = 1'b1;
      return CellMax;
    end
    if (v < CellMin) begin
      sat_seen = 1'b1;
      return CellMin;
    end
    return v;
  endfunction

  // Product scaled by 2^-20, rounded to nearest with ties away from zero.
  function automatic longint scale_product(longint a, longint b);
    longint unsigned ua;
    longint unsigned ub;
    longint unsigned r;
    bit              neg;
    neg = (a < 0) != (b < 0);
    ua  = (a < 0) ? -a : a;
    ub  = (b < 0) ? -b : b;
    r   = (ua * ub + 64'd524288) >> FracBits;
    return neg ? -longint'(r) : longint'(r);
  endfunction

  function automatic void advance_wave();
    int     nr;
    int     nc;
    int     half;
    int     jf;
    int     idx;
    bit     nb;
    longint u;
    longint un;
    longint us;
    longint ue;
    longint uw;
    longint sum;
    nr   = active_rows();
    nc   = active_cols();
    half = nc / 2;
    nb   = ~cur_sel;
    for (int i = 0; i < nr; i++) begin
      for (int j = 0; j < nc; j++) begin
        jf  = (j + half) % nc;
        idx = i * MaxColsDef + j;
        u   = grid[cur_sel][idx];
        un  = (i == 0) ? grid[cur_sel][jf] : grid[cur_sel][idx - MaxColsDef];
        us  = (i == nr - 1) ? grid[cur_sel][i * MaxColsDef + jf]
                            : grid[cur_sel][idx + MaxColsDef];
        ue  = grid[cur_sel][i * MaxColsDef + (j + 1) % nc];
        uw  = grid[cur_sel][i * MaxColsDef + (j + nc - 1) % nc];
        sum = 2 * u - grid[nb][idx]
            + scale_product(north_c[i], clamp_cell(un - u))
            + scale_product(south_c[i], clamp_cell(us - u))
            + scale_product(phi_c[i], clamp_cell(ue + uw - 2 * u));
        grid[nb][idx] = clamp_cell(sum);
      end
    end
    for (int j = 0; j < nc; j++) begin
      idx = j;
      grid[nb][idx] = clamp_cell(scale_product(grid[nb][idx], longint'({43'd0, damp_r})));
      idx = (nr - 1) * MaxColsDef + j;
      grid[nb][idx] = clamp_cell(scale_product(grid[nb][idx], longint'({43'd0, damp_r})));
    end
    cur_sel = nb;
  endfunction

  function automatic answer_t predict_answer();
    answer_t a;
    bit      row_ok;
    bit      cell_ok;
    int      idx;
    a       = '0;
    row_ok  = row_index_i < active_rows();
    cell_ok = row_ok && (col_index_i < active_cols());
    idx     = int'(row_index_i) * MaxColsDef + int'(col_index_i);
    case (req_type_i)
      REQ_WR_CUR: begin
        if (cell_ok) grid[cur_sel][idx] = longint'(cell_value_i);
        else a.status = 1'b1;
      end
      REQ_WR_PRV: begin
        if (cell_ok) grid[~cur_sel][idx] = longint'(cell_value_i);
        else a.status = 1'b1;
      end
      REQ_COEF: begin
        if (row_ok) begin
          north_c[row_index_i] = longint'(coef_north_i);
          south_c[row_index_i] = longint'(coef_south_i);
          phi_c[row_index_i]   = longint'(coef_phi_i);
        end else begin
          a.status = 1'b1;
        end
      end
      REQ_STEP: begin
        sat_seen = 1'b0;
        advance_wave();
        a.sat = sat_seen;
      end
      REQ_RD_CUR: begin
        if (cell_ok) a.value = grid[cur_sel][idx][31:0];
        else a.status = 1'b1;
      end
      default: a.status = 1'b1;
    endcase
    return a;
  endfunction

  task automatic report(string what, longint want, longint got);
    $display("%0t ns: mismatch on %s: expected %0d, got %0d", $time, what, want, got);
    fail_count_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    answer_t want;
    if (!rst_ni) begin
      rows_r  = RowsReset;
      cols_r  = ColsReset;
      damp_r  = DampReset;
      cur_sel = 1'b0;
    end else begin
      if (result_valid_o) begin
        if (answers_q.size() == 0) begin
          report("unexpected result", 0, 1);
        end else begin
          want = answers_q.pop_front();
          if (read_value_o !== want.value) report("read_value", want.value, read_value_o);
          if (status_o !== want.status) report("status", want.status, status_o);
          if (saturated_o !== want.sat) report("saturated", want.sat, saturated_o);
        end
      end
      if (start_i && !busy_o) answers_q.push_back(predict_answer());
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CFG_ROWS: rows_r = cfg_data_i[7:0];
          CFG_COLS: cols_r = cfg_data_i[8:0];
          CFG_DAMP: damp_r = cfg_data_i;
          default: ;
        endcase
      end
    end
    pending_o = answers_q.size();
  end

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// Stimulus and verdict for the spherical wave stencil step unit. Runs a
// directed phase with extreme cells, coefficients and bad requests, a row
// count clamp check, then a series of grid shapes and damping factors: each
// phase fills the whole active grid and all row coefficients, then issues
// random writes, reads, loads and steps in bursts with random gaps.
// ---------------------------------------------------------------------------
module tb;
  import sws_pkg::*;

  localparam int IdleLimit = 100000;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start_i = 1'b0;
  logic               busy_o;
  logic [2:0]         req_type_i = REQ_RD_CUR;
  logic [6:0]         row_index_i = '0;
  logic [7:0]         col_index_i = '0;
  logic signed [31:0] cell_value_i = '0;
  logic signed [31:0] coef_north_i = '0;
  logic signed [31:0] coef_south_i = '0;
  logic signed [31:0] coef_phi_i = '0;
  logic               result_valid_o;
  logic signed [31:0] read_value_o;
  logic               status_o;
  logic               saturated_o;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [1:0]         cfg_index_i = CFG_ROWS;
  logic [20:0]        cfg_data_i = '0;
  int                 fail_count;
  int                 pending;
  int                 burst_left = 0;
  int                 idle_cycles = 0;
  int                 grid_rows;
  int                 grid_cols;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  spherical_wave_stencil_step_unit u_top (.*);

  sws_checker u_checker (
    .clk_i, .rst_ni, .start_i, .busy_o, .req_type_i, .row_index_i, .col_index_i,
    .cell_value_i, .coef_north_i, .coef_south_i, .coef_phi_i, .result_valid_o,
    .read_value_o, .status_o, .saturated_o, .cfg_valid_i, .cfg_ready_o,
    .cfg_index_i, .cfg_data_i, .fail_count_o(fail_count), .pending_o(pending)
  );

  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || result_valid_o || (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("spherical_wave_stencil_step_unit test failed");
        $finish;
      end
    end
  end

  // Returns at the edge that accepts the request, with start still high.
  task automatic issue(logic [2:0] kind, logic [6:0] row, logic [7:0] col,
                       logic [31:0] value, logic [31:0] cn, logic [31:0] cs,
                       logic [31:0] cp);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
      if (gap > 0) begin
        start_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
                                               : $urandom_range(1, 8);
    end
    burst_left--;
    start_i      <= 1'b1;
    req_type_i   <= kind;
    row_index_i  <= row;
    col_index_i  <= col;
    cell_value_i <= value;
    coef_north_i <= cn;
    coef_south_i <= cs;
    coef_phi_i   <= cp;
    do @(negedge clk_i); while (busy_o);
    @(posedge clk_i);
  endtask

  task automatic drain();
    start_i <= 1'b0;
    do @(negedge clk_i); while (pending != 0 || busy_o);
    @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] index, logic [20:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i  <= data;
    do @(negedge clk_i); while (!cfg_ready_o);
    @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_cell();
    if ($urandom_range(0, 9) == 0) return $urandom;
    return 32'($signed($urandom_range(0, 1 << 25)) - (1 << 24));
  endfunction

  function automatic logic [31:0] rand_coef();
    if ($urandom_range(0, 9) == 0) return $urandom;
    return 32'($signed($urandom_range(0, 1 << 19)) - (1 << 18));
  endfunction

  task automatic configure(int rows, int cols, int damp);
    drain();
    write_reg(CFG_ROWS, 21'(rows));
    write_reg(CFG_COLS, 21'(cols));
    write_reg(CFG_DAMP, 21'(damp));
    grid_rows = (rows < 1) ? 1 : (rows > MaxRowsDef) ? MaxRowsDef : rows;
    grid_cols = (cols < 2) ? 2 : (cols > MaxColsDef) ? MaxColsDef : cols;
  endtask

  task automatic random_phase(int rows, int cols, int damp, int count);
    int k;
    configure(rows, cols, damp);
    for (int i = 0; i < grid_rows; i++) begin
      for (int j = 0; j < grid_cols; j++) begin
        issue(REQ_WR_CUR, 7'(i), 8'(j), rand_cell(), '0, '0, '0);
        issue(REQ_WR_PRV, 7'(i), 8'(j), rand_cell(), '0, '0, '0);
      end
      issue(REQ_COEF, 7'(i), 8'($urandom), '0, rand_coef(), rand_coef(), rand_coef());
    end
    for (int n = 0; n < count; n++) begin
      k = $urandom_range(0, 99);
      if (k < 30) begin
        issue(REQ_RD_CUR, 7'($urandom_range(0, grid_rows - 1)),
              8'($urandom_range(0, grid_cols - 1)),
              $urandom, $urandom, $urandom, $urandom);
      end else if (k < 45) begin
        issue(($urandom_range(0, 1) == 0) ? REQ_WR_CUR : REQ_WR_PRV,
              7'($urandom_range(0, grid_rows - 1)), 8'($urandom_range(0, grid_cols - 1)),
              rand_cell(), $urandom, $urandom, $urandom);
      end else if (k < 55) begin
        issue(REQ_COEF, 7'($urandom_range(0, grid_rows - 1)), 8'($urandom), $urandom,
              rand_coef(), rand_coef(), rand_coef());
      end else if (k < 67) begin
        issue(REQ_STEP, 7'($urandom), 8'($urandom), $urandom, $urandom, $urandom, $urandom);
      end else begin
        issue(3'($urandom), 7'($urandom), 8'($urandom), $urandom, $urandom, $urandom,
              $urandom);
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Two rows of four, full-scale values and coefficients, so the first
    // step saturates; then bad indexes and unknown requests.
    configure(2, 4, 1048576);
    for (int j = 0; j < 4; j++) begin
      issue(REQ_WR_CUR, 7'd0, 8'(j), (j % 2) ? 32'h8000_0000 : 32'h7fff_ffff, '0, '0, '0);
      issue(REQ_WR_PRV, 7'd0, 8'(j), 32'h8000_0000, '0, '0, '0);
      issue(REQ_WR_CUR, 7'd1, 8'(j), 32'hffff_ffff, '0, '0, '0);
      issue(REQ_WR_PRV, 7'd1, 8'(j), 32'h0000_0000, '0, '0, '0);
    end
    issue(REQ_COEF, 7'd0, 8'd255, '0, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    issue(REQ_COEF, 7'd1, 8'd0, '0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    issue(REQ_STEP, '0, '0, '0, '0, '0, '0);
    issue(REQ_RD_CUR, 7'd0, 8'd0, '0, '0, '0, '0);
    issue(REQ_RD_CUR, 7'd1, 8'd3, '0, '0, '0, '0);
    issue(REQ_RD_CUR, 7'd127, 8'd0, '0, '0, '0, '0);
    issue(REQ_RD_CUR, 7'd0, 8'd255, '0, '0, '0, '0);
    issue(REQ_WR_CUR, 7'd2, 8'd0, 32'h1234_5678, '0, '0, '0);
    issue(REQ_WR_PRV, 7'd0, 8'd4, 32'h1234_5678, '0, '0, '0);
    issue(REQ_COEF, 7'd127, 8'd0, '0, 32'h1, 32'h1, 32'h1);
    issue(3'd5, '0, '0, '0, '0, '0, '0);
    issue(3'd6, '0, '0, '0, '0, '0, '0);
    issue(3'd7, '0, '0, '0, '0, '0, '0);
    issue(REQ_STEP, '0, '0, '0, '0, '0, '0);
    issue(REQ_RD_CUR, 7'd1, 8'd1, '0, '0, '0, '0);

    // A row count above the maximum is clamped, so the last row is usable.
    configure(200, 2, int'(DampReset));
    issue(REQ_WR_CUR, 7'd127, 8'd1, 32'h0abc_def0, '0, '0, '0);
    issue(REQ_RD_CUR, 7'd127, 8'd1, '0, '0, '0, '0);
    issue(REQ_WR_PRV, 7'd127, 8'd2, 32'h0abc_def0, '0, '0, '0);

    random_phase(1, 511, 0, 60);
    random_phase(0, 1, 2097151, 60);
    for (int p = 0; p < 3; p++) begin
      random_phase($urandom_range(1, 4), $urandom_range(2, 8),
                   $urandom_range(900000, 1048576), 50);
    end

    drain();
    repeat (20) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("spherical_wave_stencil_step_unit test passed");
    end else begin
      $display("spherical_wave_stencil_step_unit test failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
design/sws_pkg.sv
design/sws_bank.sv
design/spherical_wave_stencil_step_unit.sv
verif/sws_checker.sv
verif/tb.sv
